// ----- design/hfa_pkg.sv -----
package hfa_pkg;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NO_SPACE  = 2'd1,
		STAT_NOT_ALLOC = 2'd2
	} hfa_status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DISP,
		S_A_CHK,
		S_A_SPLIT,
		S_A_BN,
		S_F_CHK,
		S_F_LCHK,
		S_F_RRD,
		S_F_RCHK,
		S_ABS,
		S_ABS_FIX,
		S_RM_A,
		S_RM_B,
		S_INS,
		S_INS_HEAD,
		S_OUT
	} hfa_state_t;

	typedef struct packed {
		logic prev;
		logic next;
		logic size;
		logic alloc;
		logic pfree;
		logic nfree;
	} hfa_field_en_t;

endpackage

// ----- design/hfa_req_if.sv -----
interface hfa_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] request_bytes;
	logic [14:0] payload_offset;

	modport source (output valid, action, request_bytes, payload_offset, input ready);
	modport sink (input valid, action, request_bytes, payload_offset, output ready);
endinterface

// ----- design/hfa_rsp_if.sv -----
interface hfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [14:0] granted_offset;
	logic [10:0] granted_blocks;

	modport source (output valid, status, granted_offset, granted_blocks, input ready);
	modport sink (input valid, status, granted_offset, granted_blocks, output ready);
endinterface

// ----- design/half_fit_block_allocator_top.sv -----
// Half-fit allocator over a pool of fixed-size blocks.
// Channel req: action (0 allocate, 1 free), request_bytes, payload_offset.
// Channel rsp: status, granted_offset, granted_blocks; one rsp per req.
// Both channels use valid/ready; a transfer occurs when both are high.
// The front end takes requests into a two-entry queue, computing block
// count, start size class and free-offset checks on the way in.
// The back end executes one request at a time against a header memory
// with separate write and read addresses (one write and one registered
// read per cycle). An allocate that splits also links the remainder block
// into the block chain and inserts it in its class list; a free that merges
// unlinks each free neighbor and absorbs it before inserting the result.
// Results sit in an output register; while rsp is stalled the back end
// holds its finished result and the front end keeps taking up to two more
// requests.
// After arst_n releases, state S_INIT writes the header of the single free
// block covering the whole pool before the first request is executed.
module half_fit_block_allocator_top #(
	parameter int POOL_BYTES   = 32768,
	parameter int BLOCK_BYTES  = 32,
	parameter int HEADER_BYTES = 4,
	parameter int SIZE_CLASSES = 11
) (
	input  logic      clk,
	input  logic      arst_n,
	hfa_req_if.sink   req,
	hfa_rsp_if.source rsp
);
	localparam int NBLK = POOL_BYTES / BLOCK_BYTES;
	localparam int BW   = $clog2(NBLK);
	localparam int IW   = 3 + (BW + 1) + $clog2(SIZE_CLASSES) + BW;

	logic          q_valid, q_ready;
	logic [IW-1:0] q_item;

	hfa_front #(
		.POOL_BYTES(POOL_BYTES),
		.BLOCK_BYTES(BLOCK_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.SIZE_CLASSES(SIZE_CLASSES),
		.IW(IW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	hfa_back #(
		.POOL_BYTES(POOL_BYTES),
		.BLOCK_BYTES(BLOCK_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.SIZE_CLASSES(SIZE_CLASSES),
		.IW(IW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.rsp(rsp)
	);

endmodule

// ----- design/hfa_front.sv -----
module hfa_front #(
	parameter int POOL_BYTES   = 32768,
	parameter int BLOCK_BYTES  = 32,
	parameter int HEADER_BYTES = 4,
	parameter int SIZE_CLASSES = 11,
	parameter int IW           = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	hfa_req_if.sink       req,
	output logic          q_valid,
	input  logic          q_ready,
	output logic [IW-1:0] q_item
);
	import hfa_pkg::*;

	localparam int NBLK   = POOL_BYTES / BLOCK_BYTES;
	localparam int BW     = $clog2(NBLK);
	localparam int SW     = BW + 1;
	localparam int CW     = $clog2(SIZE_CLASSES);
	localparam int BLK_SH = $clog2(BLOCK_BYTES);
	localparam int TOPC   = SIZE_CLASSES - 1;

	logic [31:0]   sum32, need32, nm1, cls32, off32, rel32, blk32;
	logic [31:0]   fl;
	logic          big, bad;
	logic [IW-1:0] item;
	logic [IW-1:0] q_mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	always_comb begin
		sum32 = 32'(req.request_bytes) + 32'(HEADER_BYTES + BLOCK_BYTES - 1);
		need32 = sum32 >> BLK_SH;
		big = need32 > 32'(NBLK);
		nm1 = need32 - 32'd1;
		fl = '0;
		for (int i = 1; i < 32; i++) begin
			if (nm1[i]) begin
				fl = 32'(i);
			end
		end
		cls32 = (need32 <= 32'd1) ? 32'd0 : fl + 32'd1;
		if (cls32 > 32'(TOPC)) begin
			cls32 = 32'(TOPC);
		end
		off32 = 32'(req.payload_offset);
		rel32 = off32 - 32'(HEADER_BYTES);
		blk32 = rel32 >> BLK_SH;
		bad = (off32 < 32'(HEADER_BYTES)) || ((rel32 & 32'(BLOCK_BYTES - 1)) != 32'd0)
			|| (blk32 >= 32'(NBLK));
		item = {req.action == ACT_FREE, bad, big, need32[SW-1:0], cls32[CW-1:0],
			blk32[BW-1:0]};
	end

	assign req.ready = cnt_q != 2'd2;
	assign push = req.valid && req.ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_item = q_mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= item;
		end
	end

endmodule

// ----- design/hfa_back.sv -----
module hfa_back #(
	parameter int POOL_BYTES   = 32768,
	parameter int BLOCK_BYTES  = 32,
	parameter int HEADER_BYTES = 4,
	parameter int SIZE_CLASSES = 11,
	parameter int IW           = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [IW-1:0] q_item,
	hfa_rsp_if.source     rsp
);
	import hfa_pkg::*;

	localparam int NBLK   = POOL_BYTES / BLOCK_BYTES;
	localparam int BW     = $clog2(NBLK);
	localparam int SW     = BW + 1;
	localparam int CW     = $clog2(SIZE_CLASSES);
	localparam int BLK_SH = $clog2(BLOCK_BYTES);
	localparam int TOPC   = SIZE_CLASSES - 1;

	function automatic logic [CW-1:0] class_of(input logic [SW-1:0] n);
		logic [31:0] r;
		r = '0;
		for (int i = 1; i < SW; i++) begin
			if (n[i]) begin
				r = 32'(i);
			end
		end
		if (r > 32'(TOPC)) begin
			r = 32'(TOPC);
		end
		return r[CW-1:0];
	endfunction

	logic [BW-1:0] mem_prev [NBLK];
	logic [BW-1:0] mem_next [NBLK];
	logic [SW-1:0] mem_size [NBLK];
	logic          mem_alloc [NBLK];
	logic [BW-1:0] mem_pfree [NBLK];
	logic [BW-1:0] mem_nfree [NBLK];

	logic [BW-1:0] rd_prev, rd_next, rd_pfree, rd_nfree;
	logic [SW-1:0] rd_size;
	logic          rd_alloc;

	hfa_state_t    state_q, state_d, ret_q;
	hfa_field_en_t w_en;
	logic [BW-1:0] w_addr, w_prev, w_next, w_pfree, w_nfree, ra;
	logic [SW-1:0] w_size;
	logic          w_alloc;

	logic          it_free, it_bad, it_big;
	logic [SW-1:0] it_need;
	logic [CW-1:0] it_cls;
	logic [BW-1:0] it_blk;

	logic [BW-1:0] head_q [SIZE_CLASSES];
	logic [SIZE_CLASSES-1:0] hvalid_q;

	logic [BW-1:0] b_q, hb_prev_q, hb_next_q, wa_q, wh_pfree_q, wh_nfree_q;
	logic [SW-1:0] hb_size_q, cur_size_q, ab_ls_q, ab_rs_q;
	logic [CW-1:0] rm_cls_q, ins_cls_q;
	logic [BW-1:0] cur_q, ins_next_q, ins_prev_q, ab_l_q, ab_r_q, ab_rn_q;
	logic          ins_new_q, ab_left_q;
	hfa_status_t   res_status_q, res_status_d;

	logic          first, last, found, rem_nz, out_load;
	logic [CW-1:0] fc, ins_c, rd_cls;
	logic [BW-1:0] n_blk;
	logic [SW-1:0] rem, ab_sum;
	logic [31:0]   off32, blk32;

	always_comb begin
		found = 1'b0;
		fc = '0;
		for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
			if (hvalid_q[c] && (CW'(c) >= it_cls)) begin
				found = 1'b1;
				fc = CW'(c);
			end
		end
	end

	assign first  = wh_pfree_q == wa_q;
	assign last   = wh_nfree_q == wa_q;
	assign n_blk  = b_q + it_need[BW-1:0];
	assign rem    = hb_size_q - it_need;
	assign rem_nz = rem != '0;
	assign ins_c  = class_of(cur_size_q);
	assign rd_cls = class_of(rd_size);
	assign ab_sum = ab_ls_q + ab_rs_q;
	assign out_load = (state_q == S_OUT) && (!rsp.valid || rsp.ready);

	always_comb begin
		state_d = state_q;
		res_status_d = res_status_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (q_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (it_free) begin
					if (it_bad) begin
						res_status_d = STAT_NOT_ALLOC;
						state_d = S_OUT;
					end else begin
						state_d = S_F_CHK;
					end
				end else if (it_big || !found) begin
					res_status_d = STAT_NO_SPACE;
					state_d = S_OUT;
				end else begin
					state_d = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (rd_size < it_need) begin
					res_status_d = STAT_NO_SPACE;
					state_d = S_OUT;
				end else begin
					state_d = S_RM_A;
				end
			end
			S_RM_A: state_d = S_RM_B;
			S_RM_B: state_d = ret_q;
			S_A_SPLIT: begin
				if (rem_nz) begin
					state_d = S_A_BN;
				end else begin
					res_status_d = STAT_DONE;
					state_d = S_OUT;
				end
			end
			S_A_BN: state_d = S_INS;
			S_F_CHK: begin
				if (!rd_alloc) begin
					res_status_d = STAT_NOT_ALLOC;
					state_d = S_OUT;
				end else if (rd_prev != b_q) begin
					state_d = S_F_LCHK;
				end else begin
					state_d = S_F_RRD;
				end
			end
			S_F_LCHK: state_d = rd_alloc ? S_F_RRD : S_RM_A;
			S_F_RRD: state_d = (hb_next_q != b_q) ? S_F_RCHK : S_INS;
			S_F_RCHK: state_d = rd_alloc ? S_INS : S_RM_A;
			S_ABS: state_d = S_ABS_FIX;
			S_ABS_FIX: state_d = ab_left_q ? S_F_RRD : S_INS;
			S_INS: state_d = S_INS_HEAD;
			S_INS_HEAD: begin
				res_status_d = STAT_DONE;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_ready = 1'b0;
		w_en = '0;
		w_addr = '0;
		w_prev = '0;
		w_next = '0;
		w_size = '0;
		w_alloc = 1'b0;
		w_pfree = '0;
		w_nfree = '0;
		ra = b_q;
		unique case (state_q)
			S_INIT: begin
				w_en = '1;
				w_size = SW'(NBLK);
			end
			S_IDLE: q_ready = 1'b1;
			S_DISP: ra = it_free ? it_blk : head_q[fc];
			S_RM_A: begin
				if (!first) begin
					w_en.nfree = 1'b1;
					w_addr = wh_pfree_q;
					w_nfree = last ? wh_pfree_q : wh_nfree_q;
				end
			end
			S_RM_B: begin
				if (!last) begin
					w_en.pfree = 1'b1;
					w_addr = wh_nfree_q;
					w_pfree = first ? wh_nfree_q : wh_pfree_q;
				end
			end
			S_A_SPLIT: begin
				w_addr = b_q;
				w_en.pfree = 1'b1;
				w_en.nfree = 1'b1;
				w_en.alloc = 1'b1;
				w_pfree = b_q;
				w_nfree = b_q;
				w_alloc = 1'b1;
				w_en.next = rem_nz;
				w_en.size = rem_nz;
				w_next = n_blk;
				w_size = it_need;
			end
			S_A_BN: begin
				if (hb_next_q != b_q) begin
					w_en.prev = 1'b1;
					w_addr = hb_next_q;
					w_prev = cur_q;
				end
			end
			S_F_CHK: begin
				if (rd_alloc) begin
					w_en.alloc = 1'b1;
					w_addr = b_q;
				end
				ra = rd_prev;
			end
			S_F_RRD: ra = hb_next_q;
			S_ABS: begin
				w_addr = ab_l_q;
				w_en.next = 1'b1;
				w_en.size = 1'b1;
				w_next = (ab_rn_q == ab_r_q) ? ab_l_q : ab_rn_q;
				w_size = ab_sum;
			end
			S_ABS_FIX: begin
				if (ab_rn_q != ab_r_q) begin
					w_en.prev = 1'b1;
					w_addr = ab_rn_q;
					w_prev = ab_l_q;
				end
			end
			S_INS: begin
				w_addr = cur_q;
				w_en.pfree = 1'b1;
				w_en.nfree = 1'b1;
				w_en.size = 1'b1;
				w_pfree = cur_q;
				w_nfree = hvalid_q[ins_c] ? head_q[ins_c] : cur_q;
				w_size = cur_size_q;
				w_en.next = ins_new_q;
				w_en.prev = ins_new_q;
				w_en.alloc = ins_new_q;
				w_next = ins_next_q;
				w_prev = ins_prev_q;
			end
			S_INS_HEAD: begin
				if (hvalid_q[ins_cls_q]) begin
					w_en.pfree = 1'b1;
					w_addr = head_q[ins_cls_q];
					w_pfree = cur_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_en.prev) mem_prev[w_addr] <= w_prev;
		if (w_en.next) mem_next[w_addr] <= w_next;
		if (w_en.size) mem_size[w_addr] <= w_size;
		if (w_en.alloc) mem_alloc[w_addr] <= w_alloc;
		if (w_en.pfree) mem_pfree[w_addr] <= w_pfree;
		if (w_en.nfree) mem_nfree[w_addr] <= w_nfree;
		rd_prev <= mem_prev[ra];
		rd_next <= mem_next[ra];
		rd_size <= mem_size[ra];
		rd_alloc <= mem_alloc[ra];
		rd_pfree <= mem_pfree[ra];
		rd_nfree <= mem_nfree[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			hvalid_q <= {1'b1, {(SIZE_CLASSES - 1){1'b0}}};
			for (int c = 0; c < SIZE_CLASSES; c++) begin
				head_q[c] <= '0;
			end
			rsp.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RM_B && first) begin
				if (last) begin
					hvalid_q[rm_cls_q] <= 1'b0;
				end else begin
					head_q[rm_cls_q] <= wh_nfree_q;
				end
			end
			if (state_q == S_INS_HEAD) begin
				head_q[ins_cls_q] <= cur_q;
				hvalid_q[ins_cls_q] <= 1'b1;
			end
			if (out_load) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	assign off32 = (32'(b_q) << BLK_SH) + 32'(HEADER_BYTES);
	assign blk32 = 32'(it_need);

	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		if (out_load) begin
			rsp.status <= res_status_q;
			if (!it_free && res_status_q == STAT_DONE) begin
				rsp.granted_offset <= off32[14:0];
				rsp.granted_blocks <= blk32[10:0];
			end else begin
				rsp.granted_offset <= '0;
				rsp.granted_blocks <= '0;
			end
		end
		unique case (state_q)
			S_IDLE: begin
				{it_free, it_bad, it_big, it_need, it_cls, it_blk} <= q_item;
			end
			S_DISP: b_q <= it_free ? it_blk : head_q[fc];
			S_A_CHK: begin
				wa_q <= b_q;
				wh_pfree_q <= rd_pfree;
				wh_nfree_q <= rd_nfree;
				rm_cls_q <= rd_cls;
				hb_next_q <= rd_next;
				hb_size_q <= rd_size;
				ret_q <= S_A_SPLIT;
			end
			S_A_SPLIT: begin
				cur_q <= n_blk;
				cur_size_q <= rem;
				ins_new_q <= 1'b1;
				ins_next_q <= (hb_next_q == b_q) ? n_blk : hb_next_q;
				ins_prev_q <= b_q;
			end
			S_F_CHK: begin
				hb_prev_q <= rd_prev;
				hb_next_q <= rd_next;
				hb_size_q <= rd_size;
				cur_q <= b_q;
				cur_size_q <= rd_size;
				ins_new_q <= 1'b0;
			end
			S_F_LCHK: begin
				wa_q <= hb_prev_q;
				wh_pfree_q <= rd_pfree;
				wh_nfree_q <= rd_nfree;
				rm_cls_q <= rd_cls;
				ret_q <= S_ABS;
				ab_left_q <= 1'b1;
				ab_l_q <= hb_prev_q;
				ab_r_q <= b_q;
				ab_rn_q <= hb_next_q;
				ab_rs_q <= hb_size_q;
				ab_ls_q <= rd_size;
			end
			S_F_RCHK: begin
				wa_q <= hb_next_q;
				wh_pfree_q <= rd_pfree;
				wh_nfree_q <= rd_nfree;
				rm_cls_q <= rd_cls;
				ret_q <= S_ABS;
				ab_left_q <= 1'b0;
				ab_l_q <= cur_q;
				ab_r_q <= hb_next_q;
				ab_rn_q <= rd_next;
				ab_rs_q <= rd_size;
				ab_ls_q <= cur_size_q;
			end
			S_ABS: begin
				cur_q <= ab_l_q;
				cur_size_q <= ab_sum;
			end
			S_INS: ins_cls_q <= ins_c;
			default: ;
		endcase
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> w_en == '0)
		else $error("header write while idle");

	a_unlink_return: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RM_B |=> state_q == $past(ret_q))
		else $error("unlink did not return to caller");

	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_HEAD |=> hvalid_q[$past(ins_cls_q)])
		else $error("class list empty after insert");

	a_split_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_SPLIT && rem_nz |-> 32'(b_q) + 32'(it_need) < 32'(NBLK))
		else $error("split remainder beyond pool");

endmodule

// ----- test/tb_top.sv -----
module tb_top;
	import hfa_pkg::*;

	localparam int POOL_BYTES   = 32768;
	localparam int BLOCK_BYTES  = 32;
	localparam int HEADER_BYTES = 4;
	localparam int SIZE_CLASSES = 11;
	localparam int NBLK         = POOL_BYTES / BLOCK_BYTES;
	localparam int TOPC         = SIZE_CLASSES - 1;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		int unsigned prev, next, size, pfree, nfree;
		bit          alloc;
	} blk_hdr_t;

	typedef struct {
		hfa_status_t status;
		logic [14:0] offset;
		logic [10:0] blocks;
	} grant_t;

	class alloc_scoreboard;
		blk_hdr_t    hdr[NBLK];
		int unsigned head[SIZE_CLASSES];
		bit          head_ok[SIZE_CLASSES];
		grant_t      pending[$];
		int          errors;
		logic [14:0] live[$];

		function new();
			hdr[0] = '{0, 0, NBLK, 0, 0, 1'b0};
			head_ok[TOPC] = 1'b1;
			head[TOPC] = 0;
			errors = 0;
		endfunction

		function int unsigned size_class(int unsigned n);
			int unsigned r;
			r = 0;
			while (n > 1) begin
				n >>= 1;
				r++;
			end
			return (r > TOPC) ? TOPC : r;
		endfunction

		function void unlink(int unsigned x);
			int unsigned c, p, n;
			c = size_class(hdr[x].size);
			p = hdr[x].pfree;
			n = hdr[x].nfree;
			if (n != x) begin
				if (p != x) begin
					hdr[p].nfree = n;
					hdr[n].pfree = p;
				end else begin
					head[c] = n;
					hdr[n].pfree = n;
				end
			end else if (p != x) begin
				hdr[p].nfree = p;
			end else begin
				head_ok[c] = 1'b0;
			end
			hdr[x].pfree = x;
			hdr[x].nfree = x;
		endfunction

		function void link(int unsigned x);
			int unsigned c;
			c = size_class(hdr[x].size);
			if (head_ok[c]) begin
				hdr[head[c]].pfree = x;
				hdr[x].nfree = head[c];
			end else begin
				hdr[x].nfree = x;
			end
			hdr[x].pfree = x;
			head[c] = x;
			head_ok[c] = 1'b1;
		endfunction

		function void merge_right(int unsigned l, int unsigned r);
			int unsigned rn;
			rn = hdr[r].next;
			if (rn == r) begin
				hdr[l].next = l;
			end else begin
				hdr[l].next = rn;
				hdr[rn].prev = l;
			end
			hdr[l].size += hdr[r].size;
		endfunction

		function grant_t grant(int unsigned req);
			grant_t g;
			int unsigned need, c, b, n, bn, m;
			g = '{STAT_NO_SPACE, '0, '0};
			need = (req + HEADER_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
			if (need == 0) need = 1;
			if (need > NBLK) return g;
			c = 0;
			m = need - 1;
			while (m > 0) begin
				m >>= 1;
				c++;
			end
			if (c > TOPC) c = TOPC;
			while (c <= TOPC && !head_ok[c]) c++;
			if (c > TOPC) return g;
			b = head[c];
			if (hdr[b].size < need) return g;
			unlink(b);
			if (hdr[b].size > need) begin
				n = b + need;
				bn = hdr[b].next;
				if (bn == b) begin
					hdr[n].next = n;
				end else begin
					hdr[n].next = bn;
					hdr[bn].prev = n;
				end
				hdr[n].prev = b;
				hdr[n].size = hdr[b].size - need;
				hdr[n].alloc = 1'b0;
				hdr[b].next = n;
				hdr[b].size = need;
				link(n);
			end
			hdr[b].alloc = 1'b1;
			g.status = STAT_DONE;
			g.offset = 15'(b * BLOCK_BYTES + HEADER_BYTES);
			g.blocks = 11'(need);
			live.push_back(g.offset);
			return g;
		endfunction

		function grant_t release_blk(int unsigned off);
			grant_t g;
			int unsigned b, l, r, cur;
			g = '{STAT_NOT_ALLOC, '0, '0};
			if (off < HEADER_BYTES || (off - HEADER_BYTES) % BLOCK_BYTES != 0) return g;
			b = (off - HEADER_BYTES) / BLOCK_BYTES;
			if (b >= NBLK || !hdr[b].alloc) return g;
			hdr[b].alloc = 1'b0;
			foreach (live[i]) if (live[i] == off) begin
				live.delete(i);
				break;
			end
			cur = b;
			l = hdr[b].prev;
			r = hdr[b].next;
			if (l != b && !hdr[l].alloc) begin
				unlink(l);
				merge_right(l, b);
				cur = l;
			end
			if (r != b && !hdr[r].alloc) begin
				unlink(r);
				merge_right(cur, r);
			end
			link(cur);
			g.status = STAT_DONE;
			return g;
		endfunction

		function void note_request(logic act, logic [15:0] req, logic [14:0] off);
			if (act == ACT_ALLOC) pending.push_back(grant(req));
			else pending.push_back(release_blk(off));
		endfunction

		function void check_result(logic [1:0] st, logic [14:0] off, logic [10:0] blk);
			grant_t e;
			if (pending.size() == 0) begin
				$error("unexpected transfer: status %0d", st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (off !== e.offset) begin
				$error("granted_offset: expected %0d, actual %0d", e.offset, off);
				errors++;
			end
			if (blk !== e.blocks) begin
				$error("granted_blocks: expected %0d, actual %0d", e.blocks, blk);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	hfa_req_if req ();
	hfa_rsp_if rsp ();
	alloc_scoreboard sb;
	int cycles;
	bit quiet;

	half_fit_block_allocator_top #(
		.POOL_BYTES(POOL_BYTES),
		.BLOCK_BYTES(BLOCK_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.SIZE_CLASSES(SIZE_CLASSES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			sb.note_request(req.action, req.request_bytes, req.payload_offset);
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.status, rsp.granted_offset, rsp.granted_blocks);
	end

	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				rsp.ready = 1'b0;
				gap = $urandom_range(1, 12);
				repeat (gap) @(negedge clk);
			end
			rsp.ready = 1'b1;
		end
	end

	task automatic send(logic act, logic [15:0] bytes, logic [14:0] off);
		int gap;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			req.valid = 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		req.valid = 1'b1;
		req.action = act;
		req.request_bytes = bytes;
		req.payload_offset = off;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic drain();
		req.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic free_live();
		int k;
		k = $urandom_range(0, sb.live.size() - 1);
		send(ACT_FREE, 16'h0, sb.live[k]);
	endtask

	initial begin
		int r;
		logic [15:0] bytes;
		sb = new();
		cycles = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_ALLOC;
		req.request_bytes = '0;
		req.payload_offset = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(ACT_FREE, 16'h0, 15'd4);
		send(ACT_ALLOC, 16'd0, '0);
		send(ACT_ALLOC, 16'd28, '0);
		send(ACT_ALLOC, 16'd29, '0);
		send(ACT_ALLOC, 16'hFFFF, '0);
		send(ACT_ALLOC, 16'd32768, '0);
		send(ACT_ALLOC, 16'd20000, '0);
		send(ACT_ALLOC, 16'd20000, '0);
		send(ACT_FREE, 16'h0, 15'd0);
		send(ACT_FREE, 16'h0, 15'd5);
		send(ACT_FREE, 16'h0, 15'h7FFF);
		send(ACT_FREE, 16'h0, 15'd36);
		send(ACT_FREE, 16'h0, 15'd36);
		send(ACT_FREE, 16'h0, 15'd4);
		send(ACT_FREE, 16'h0, 15'd68);
		send(ACT_ALLOC, 16'd32764, '0);
		send(ACT_FREE, 16'h0, 15'd4);
		send(ACT_ALLOC, 16'd32765, '0);
		send(ACT_ALLOC, 16'd100, '0);
		drain();

		for (int i = 0; i < 1150; i++) begin
			if (i > 1000) quiet = 1'b1;
			if (i == 500) drain();
			r = $urandom_range(0, 99);
			if (r < 45) begin
				case ($urandom_range(0, 3))
					0: bytes = 16'($urandom_range(0, 60));
					1: bytes = 16'($urandom_range(0, 600));
					2: bytes = 16'($urandom_range(0, 4000));
					default: bytes = 16'($urandom);
				endcase
				send(ACT_ALLOC, bytes, '0);
			end else if (r < 92 && sb.live.size() != 0) begin
				free_live();
			end else if (r < 96) begin
				send(ACT_FREE, 16'($urandom),
					15'($urandom_range(0, NBLK - 1) * BLOCK_BYTES + HEADER_BYTES));
			end else begin
				send(ACT_FREE, 16'($urandom), 15'($urandom));
			end
		end
		drain();
		repeat (40) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
